FILE: rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and codes for the homogeneous point transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

	localparam int WORD_W  = 32;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_POINT  = 2'd1,
		OP_VECTOR = 2'd2,
		OP_BOX    = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WZERO = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		op_t                    op;
		logic [3:0]             coef_index;
		logic [WORD_W-1:0]      coef_value;
		logic [2:0][WORD_W-1:0] lo;
		logic [2:0][WORD_W-1:0] hi;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/core/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of points, vectors and boxes in signed fixed point.
// ----------------------------------------------------------------------------
// Items enter through a four-entry queue, so the block takes an item in every
// cycle until that queue fills, and results leave through a one-item output
// register. A coefficient load is written into the matrix from the idle
// state. A vector runs sixteen multiplies on the single 32x32 multiplier (one
// matrix entry each), a drain step, a check step and the result write. A
// point adds the three parallel restoring dividers, which produce one quotient
// bit per cycle over 64+3 bits, then a wait for the divider to finish and a
// post step that folds the quotients in; a point whose w is zero skips the
// division. A box repeats the point sequence for each of its eight corners.
// The matrix resets to the identity.
`default_nettype none

module homogeneous_point_transform #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         cmd,
	input  wire logic [3:0]         coef_index,
	input  wire logic signed [31:0] coef_value,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire logic signed [31:0] in_hi_x,
	input  wire logic signed [31:0] in_hi_y,
	input  wire logic signed [31:0] in_hi_z,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic signed [31:0]      out_hi_x,
	output logic signed [31:0]      out_hi_y,
	output logic signed [31:0]      out_hi_z,
	output logic [1:0]              status
);

	logic             q_valid, q_pop, out_valid;
	hpt_pkg::item_t   q_item;
	logic [2:0][31:0] out_lo, out_hi;

	// The front decodes and queues items so the host waits on math only once the queue is full.
	hpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.in_hi_x    (in_hi_x),
		.in_hi_y    (in_hi_y),
		.in_hi_z    (in_hi_z),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// The back runs the multiply-accumulate and division sequence.
	hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_pop    (pop),
		.out_lo     (out_lo),
		.out_hi     (out_hi),
		.out_status (status)
	);

	assign empty    = !out_valid;
	assign out_x    = $signed(out_lo[0]);
	assign out_y    = $signed(out_lo[1]);
	assign out_z    = $signed(out_lo[2]);
	assign out_hi_x = $signed(out_hi[0]);
	assign out_hi_y = $signed(out_hi[1]);
	assign out_hi_z = $signed(out_hi[2]);

	// A zero w result carries all-zero coordinates.
	a_wzero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == hpt_pkg::ST_WZERO) |-> (out_x == 0 && out_y == 0
		&& out_z == 0 && out_hi_x == 0 && out_hi_y == 0 && out_hi_z == 0))
		else $error("zero w result has nonzero coordinates");

	// A waiting result only ever carries one of the three defined status codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == hpt_pkg::ST_OK || status == hpt_pkg::ST_WZERO
		|| status == hpt_pkg::ST_SAT))
		else $error("undefined status code on result");

endmodule

`default_nettype wire

FILE: rtl/core/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front
// Accepts items, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          cmd,
	input  wire logic [3:0]          coef_index,
	input  wire logic signed [31:0]  coef_value,
	input  wire logic signed [31:0]  in_x,
	input  wire logic signed [31:0]  in_y,
	input  wire logic signed [31:0]  in_z,
	input  wire logic signed [31:0]  in_hi_x,
	input  wire logic signed [31:0]  in_hi_y,
	input  wire logic signed [31:0]  in_hi_z,
	output logic                     q_valid,
	output hpt_pkg::item_t           q_item,
	input  wire logic                q_pop
);

	hpt_pkg::item_t                   mem_q [hpt_pkg::QDEPTH];
	logic [hpt_pkg::QPTR_W-1:0]       wr_q, rd_q;
	logic [hpt_pkg::QPTR_W:0]         cnt_q;
	hpt_pkg::item_t                   item;
	logic                             wr_en, rd_en;

	always_comb begin
		item            = '0;
		item.op         = hpt_pkg::op_t'(cmd);
		item.coef_index = coef_index;
		item.coef_value = coef_value;
		item.lo         = {in_z, in_y, in_x};
		// Box maximum matters only to box items.
		if (item.op == hpt_pkg::OP_BOX) begin
			item.hi = {in_hi_z, in_hi_y, in_hi_x};
		end
	end

	assign full    = (cnt_q == (hpt_pkg::QPTR_W+1)'(hpt_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hpt_divider.sv
// ----------------------------------------------------------------------------
// hpt_divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_divider #(
	parameter int FRAC_BITS = 16,
	parameter int SUM_W     = 51
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] num,
	input  wire logic signed [SUM_W-1:0] den,
	output logic                         done,
	output logic [31:0]                  quo,
	output logic                         over
);

	localparam int DW = SUM_W + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic              busy_q, done_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [SUM_W-1:0]  rem_q, ud_q, un, ud;
	logic [DW-1:0]     dvd_q, quo_q, limit;
	logic [SUM_W:0]    rem_sh, rem_sub;
	logic              ge;
	logic [31:0]       mag;

	assign un      = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign ud      = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
	assign rem_sh  = {rem_q, dvd_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, ud_q};
	assign ge      = (rem_sh >= {1'b0, ud_q});
	assign limit   = {{(DW-32){1'b0}}, neg_q, {31{~neg_q}}};
	assign over    = (quo_q > limit);
	assign mag     = over ? limit[31:0] : quo_q[31:0];
	assign quo     = neg_q ? (32'd0 - mag) : mag;
	assign done    = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {un, {FRAC_BITS{1'b0}}};
			ud_q  <= ud;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[SUM_W-1] ^ den[SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hpt_back.sv
// ----------------------------------------------------------------------------
// hpt_back
// Executes items: matrix store, multiply-accumulate sequencer, three
// dividers, box min/max and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  hpt_pkg::item_t           q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_pop,
	output logic [2:0][31:0]         out_lo,
	output logic [2:0][31:0]         out_hi,
	output logic [1:0]               out_status
);

	localparam int SUM_W = 64 - FRAC_BITS + 3;

	typedef enum logic [2:0] {
		S_IDLE, S_MAC, S_DRAIN, S_CHECK, S_DIV, S_POST, S_EMIT
	} state_t;

	state_t                        state_q;
	hpt_pkg::item_t                item_q;
	logic [31:0]                   mat_q [16];
	logic [3:0]                    cnt_q;
	logic [2:0]                    corner_q;
	logic signed [SUM_W-1:0]       acc_q [4];
	logic signed [63:0]            prod_s1;
	logic [1:0]                    row_s1;
	logic                          valid_s1;
	logic                          sat_q, wz_q, div_start;
	logic [2:0][31:0]              res_lo_q, res_hi_q;
	logic signed [31:0]            operand;
	logic signed [63:0]            prod_sh;
	logic [2:0]                    div_done, div_over;
	logic [2:0][31:0]              div_quo;
	logic [2:0][31:0]              vclamp;
	logic [2:0]                    vsat;

	// Column three multiplies the translation coefficient by one for points and boxes, and by zero for vectors.
	always_comb begin
		if (cnt_q[1:0] == 2'd3) begin
			operand = (item_q.op == hpt_pkg::OP_VECTOR) ? 32'sd0 : 32'sd1 <<< FRAC_BITS;
		end else if (corner_q[cnt_q[1:0]]) begin
			operand = $signed(item_q.hi[cnt_q[1:0]]);
		end else begin
			operand = $signed(item_q.lo[cnt_q[1:0]]);
		end
	end

	assign prod_sh   = prod_s1 >>> FRAC_BITS;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign div_start = (state_q == S_CHECK) && (item_q.op != hpt_pkg::OP_VECTOR)
		&& (acc_q[3] != '0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vsat[i]   = 1'b1;
			if (acc_q[i] > $signed(SUM_W'(32'sh7fffffff))) begin
				vclamp[i] = 32'h7fffffff;
			end else if (acc_q[i] < -$signed(SUM_W'(64'sh80000000))) begin
				vclamp[i] = 32'h80000000;
			end else begin
				vclamp[i] = acc_q[i][31:0];
				vsat[i]   = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		hpt_divider #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (acc_q[g]),
			.den    (acc_q[3]),
			.done   (div_done[g]),
			.quo    (div_quo[g]),
			.over   (div_over[g])
		);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(mat_q[cnt_q]) * operand;
		row_s1  <= cnt_q[3:2];
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_s1  <= 1'b0;
			cnt_q     <= '0;
			corner_q  <= '0;
			sat_q     <= 1'b0;
			wz_q      <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
			end
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			valid_s1 <= (state_q == S_MAC);
			if (valid_s1) begin
				acc_q[row_s1] <= acc_q[row_s1] + prod_sh[SUM_W-1:0];
			end
			if (out_valid && out_pop) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == hpt_pkg::OP_LOAD) begin
							mat_q[q_item.coef_index] <= q_item.coef_value;
						end else begin
							cnt_q    <= '0;
							corner_q <= '0;
							sat_q    <= 1'b0;
							wz_q     <= 1'b0;
							for (int i = 0; i < 4; i++) begin
								acc_q[i] <= '0;
							end
							state_q <= S_MAC;
						end
					end
				end
				S_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (item_q.op == hpt_pkg::OP_VECTOR) begin
						res_lo_q <= vclamp;
						sat_q    <= |vsat;
						state_q  <= S_EMIT;
					end else if (acc_q[3] == '0) begin
						wz_q    <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done[0]) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					sat_q <= sat_q | (|div_over);
					for (int i = 0; i < 3; i++) begin
						if (corner_q == 3'd0
							|| $signed(div_quo[i]) < $signed(res_lo_q[i])) begin
							res_lo_q[i] <= div_quo[i];
						end
						if (corner_q == 3'd0
							|| $signed(div_quo[i]) > $signed(res_hi_q[i])) begin
							res_hi_q[i] <= div_quo[i];
						end
					end
					if (item_q.op == hpt_pkg::OP_BOX && corner_q != 3'd7) begin
						corner_q <= corner_q + 1'b1;
						cnt_q    <= '0;
						for (int i = 0; i < 4; i++) begin
							acc_q[i] <= '0;
						end
						state_q <= S_MAC;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid || out_pop) begin
						out_valid <= 1'b1;
						if (wz_q) begin
							out_lo     <= '0;
							out_hi     <= '0;
							out_status <= hpt_pkg::ST_WZERO;
						end else begin
							out_lo     <= res_lo_q;
							out_hi     <= (item_q.op == hpt_pkg::OP_BOX) ? res_hi_q : '0;
							out_status <= sat_q ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: bench/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Watches both queue sides of the point transform, predicts every result
// from its own copy of the matrix and compares it field by field.
// ----------------------------------------------------------------------------
module hpt_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         cmd,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [31:0] in_hi_x,
	input  logic signed [31:0] in_hi_y,
	input  logic signed [31:0] in_hi_z,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_z,
	input  logic signed [31:0] out_hi_x,
	input  logic signed [31:0] out_hi_y,
	input  logic signed [31:0] out_hi_z,
	input  logic [1:0]         status,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0][31:0] coord;
		logic [1:0]       st;
	} xform_result_t;

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint NEG_MIN = -64'sd2147483648;

	logic [31:0] matrix [16];
	xform_result_t results_due[$];

	function automatic longint scaled_mul(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint row_dot(int row, longint v[3], bit affine);
		longint s;
		s = 0;
		for (int c = 0; c < 3; c++)
			s += scaled_mul(longint'($signed(matrix[row*4+c])), v[c]);
		if (affine)
			s += longint'($signed(matrix[row*4+3]));
		return s;
	endfunction

	function automatic longint clamp_word(longint v, inout bit sat);
		if (v > POS_MAX) begin
			sat = 1;
			return POS_MAX;
		end
		if (v < NEG_MIN) begin
			sat = 1;
			return NEG_MIN;
		end
		return v;
	endfunction

	// Long division that stops as soon as the quotient passes the clamp limit,
	// so the shifted numerator never has to fit in 64 bits.
	function automatic longint frac_divide(longint num, longint den, inout bit sat);
		bit neg, over;
		logic [63:0] un, ud, q, r, lim;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		q = un / ud;
		r = un % ud;
		over = q > lim;
		for (int i = 0; i < FRAC_BITS && !over; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r -= ud;
				q += 1;
			end
			if (q > lim) over = 1;
		end
		if (over) begin
			sat = 1;
			q = lim;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit project_point(longint p[3], output longint o[3], inout bit sat);
		longint w;
		w = row_dot(3, p, 1);
		o = '{0, 0, 0};
		if (w == 0) return 0;
		for (int i = 0; i < 3; i++)
			o[i] = frac_divide(row_dot(i, p, 1), w, sat);
		return 1;
	endfunction

	function automatic xform_result_t predict_transform(logic [1:0] op,
			logic [2:0][31:0] lo_in, logic [2:0][31:0] hi_in);
		longint lo[3], hi[3], rlo[3], rhi[3], p[3], o[3];
		bit sat, wzero;
		xform_result_t res;
		sat = 0;
		wzero = 0;
		for (int i = 0; i < 3; i++) begin
			lo[i] = longint'($signed(lo_in[i]));
			hi[i] = longint'($signed(hi_in[i]));
			rlo[i] = 0;
			rhi[i] = 0;
		end
		if (op == hpt_pkg::OP_POINT) begin
			if (!project_point(lo, rlo, sat)) wzero = 1;
		end else if (op == hpt_pkg::OP_VECTOR) begin
			for (int i = 0; i < 3; i++) rlo[i] = clamp_word(row_dot(i, lo, 0), sat);
		end else begin
			// Eight corners; a zero w anywhere wipes the whole box.
			for (int k = 0; k < 8 && !wzero; k++) begin
				for (int i = 0; i < 3; i++) p[i] = ((k >> i) & 1) ? hi[i] : lo[i];
				if (!project_point(p, o, sat)) wzero = 1;
				else for (int i = 0; i < 3; i++) begin
					if (k == 0 || o[i] < rlo[i]) rlo[i] = o[i];
					if (k == 0 || o[i] > rhi[i]) rhi[i] = o[i];
				end
			end
		end
		if (wzero) begin
			res.coord = '0;
			res.st = hpt_pkg::ST_WZERO;
		end else begin
			for (int i = 0; i < 3; i++) begin
				res.coord[i] = rlo[i][31:0];
				res.coord[3+i] = rhi[i][31:0];
			end
			res.st = sat ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	assign pending = results_due.size();

	always @(posedge clk or negedge arst_n) begin
		xform_result_t exp_res;
		logic [5:0][31:0] got;
		if (!arst_n) begin
			errors <= 0;
			results_due.delete();
			for (int i = 0; i < 16; i++)
				matrix[i] = (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
		end else begin
			if (pop && !empty) begin
				got = {out_hi_z, out_hi_y, out_hi_x, out_z, out_y, out_x};
				if (results_due.size() == 0) begin
					report_mismatch("unexpected result", got[0], 32'd0);
				end else begin
					exp_res = results_due.pop_front();
					for (int i = 0; i < 6; i++)
						if (got[i] !== exp_res.coord[i])
							report_mismatch($sformatf("coord %0d", i), got[i], exp_res.coord[i]);
					if (status !== exp_res.st)
						report_mismatch("status", status, exp_res.st);
				end
			end
			if (push && !full) begin
				if (cmd == hpt_pkg::OP_LOAD) matrix[coef_index] = coef_value;
				else results_due.push_back(predict_transform(cmd,
						{in_z, in_y, in_x}, {in_hi_z, in_hi_y, in_hi_x}));
			end
		end
	end
endmodule

FILE: bench/tb_homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform
// Drives coefficient loads, points, vectors and boxes into the transform
// with random gaps and stalls; a checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb_homogeneous_point_transform;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE = 1 << 16;
	localparam longint CYCLE_LIMIT = 6000000;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic [1:0] cmd = hpt_pkg::OP_LOAD;
	logic [3:0] coef_index = '0;
	logic signed [31:0] coef_value = '0;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic signed [31:0] in_hi_x = '0, in_hi_y = '0, in_hi_z = '0;
	logic full, empty;
	logic signed [31:0] out_x, out_y, out_z, out_hi_x, out_hi_y, out_hi_z;
	logic [1:0] status;
	int errors, pending;
	longint cycles = 0;
	// When set, the result side stops popping for a long stretch.
	bit hold_results = 0;

	homogeneous_point_transform dut (.*);
	hpt_checker check (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Watchdog: ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_homogeneous_point_transform: done, errors");
			$finish;
		end
	end

	// Gap lengths: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Result side: pop with random stalls, except during a forced hold-off.
	always @(posedge clk) begin
		if (!arst_n || hold_results) pop <= 0;
		else pop <= ($urandom_range(3) != 0);
	end

	// Presents one item and waits until the block takes it.
	task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [31:0] cv,
			logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
		cmd <= op;
		coef_index <= idx;
		coef_value <= cv;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_hi_x <= hx;
		in_hi_y <= hy;
		in_hi_z <= hz;
		push <= 1;
		do @(posedge clk); while (full);
	endtask

	task automatic idle_for(int n);
		if (n > 0) begin
			push <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic load_coef(int idx, logic [31:0] v);
		send_item(hpt_pkg::OP_LOAD, idx[3:0], v, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
	endtask

	// Coordinates: mostly moderate, sometimes any 32-bit pattern.
	function automatic logic [31:0] rand_coord();
		if ($urandom_range(4) == 0) return $urandom;
		return $signed($urandom_range(2 * 200 * ONE)) - 200 * ONE;
	endfunction

	// Matrix entries: moderate, zero, or raw bits.
	function automatic logic [31:0] rand_coef();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 0;
		if (r == 1) return $urandom;
		return $signed($urandom_range(8 * ONE)) - 4 * ONE;
	endfunction

	task automatic send_random_transform();
		int r;
		logic [1:0] op;
		logic [31:0] x, y, z;
		r = $urandom_range(19);
		op = (r < 10) ? hpt_pkg::OP_POINT : (r < 18) ? hpt_pkg::OP_VECTOR : hpt_pkg::OP_BOX;
		x = rand_coord();
		y = rand_coord();
		z = rand_coord();
		// Box maximums are usually above the minimums but not always.
		send_item(op, 4'($urandom), $urandom, x, y, z,
			x + $urandom_range(20 * ONE), y + $urandom_range(20 * ONE),
			z + $urandom_range(20 * ONE));
	endtask

	task automatic drain();
		push <= 0;
		// Let the checker record the last accepted item first.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// A trailing load may still be in the unit.
		repeat (20) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity, extremes, zero w, saturation, all operations.
		send_item(hpt_pkg::OP_POINT, 0, 0, ONE, -ONE, 3 * ONE, 0, 0, 0);
		send_item(hpt_pkg::OP_VECTOR, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
		send_item(hpt_pkg::OP_BOX, 0, 0, -ONE, -2 * ONE, 0, ONE, 2 * ONE, 5 * ONE);
		send_item(hpt_pkg::OP_BOX, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		load_coef(15, 0);
		send_item(hpt_pkg::OP_POINT, 0, 0, ONE, ONE, ONE, 0, 0, 0);
		send_item(hpt_pkg::OP_BOX, 0, 0, 0, 0, 0, ONE, ONE, ONE);
		load_coef(15, 1);
		send_item(hpt_pkg::OP_POINT, 0, 0, 32'h7fffffff, 32'h80000000, ONE, 0, 0, 0);
		send_item(hpt_pkg::OP_BOX, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
		load_coef(0, 32'h7fffffff);
		load_coef(5, 32'h80000000);
		send_item(hpt_pkg::OP_VECTOR, 0, 0, 32'h7fffffff, 32'h7fffffff, -1, 0, 0, 0);
		load_coef(12, ONE);
		load_coef(15, -ONE);
		send_item(hpt_pkg::OP_POINT, 0, 0, -ONE, 5, 7, 0, 0, 0);
		send_item(hpt_pkg::OP_BOX, 0, 0, -ONE, 0, 0, ONE, 0, 0);
		load_coef(3, 32'hffffffff);
		send_item(hpt_pkg::OP_POINT, 0, 0, -1, -1, -1, 0, 0, 0);
		drain();

		// Random: mostly transforms, every so often the matrix changes.
		for (int n = 0; n < 1300; n++) begin
			if (n == 400) begin
				// Result side stalls while items keep coming, so the queue fills.
				fork
					begin
						hold_results = 1;
						repeat (3000) @(posedge clk);
						hold_results = 0;
					end
				join_none
			end
			if (n == 900) drain();
			if ($urandom_range(7) == 0) begin
				if ($urandom_range(5) == 0)
					for (int i = 0; i < 16; i++) load_coef(i, rand_coef());
				else load_coef($urandom_range(15), rand_coef());
			end else begin
				send_random_transform();
			end
			idle_for(gap_len());
		end
		drain();

		if (errors == 0) $display("tb_homogeneous_point_transform: done, clean");
		else $display("tb_homogeneous_point_transform: done, errors");
		$finish;
	end
endmodule
